>>> rtl/core/touch_wheel_wrap_guard_assert.svh
// Assertion macros for the touch wheel wrap guard.
`ifndef TOUCH_WHEEL_WRAP_GUARD_ASSERT_SVH
`define TOUCH_WHEEL_WRAP_GUARD_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TWWG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define TWWG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/twwg_pkg.sv
// Types and constants shared by the touch wheel wrap guard.
package twwg_pkg;

  typedef enum logic {
    OpLocal  = 1'b0,
    OpRemote = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] wheel_value;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  brightness;
    logic [26:0] ring_mask;
  } out_item_t;

  // Direction machine, one-hot.
  typedef enum logic [3:0] {
    DirCwTrack  = 4'b0001,
    DirCwBlock  = 4'b0010,
    DirCcwTrack = 4'b0100,
    DirCcwBlock = 4'b1000
  } dir_e;

  localparam logic [7:0]  JumpLimitReset  = 8'd100;
  localparam int unsigned RingLedsDefault = 24;
  localparam logic [7:0]  RingClampValue  = 8'd240;
  localparam logic [7:0]  RingFullValue   = 8'd255;

  // v / 11 == (v * 745) >> 13 for every 8-bit v
  localparam logic [17:0] DivElevenMul   = 18'd745;
  localparam int unsigned DivElevenShift = 13;

  // Shift register bit for each ring position.
  localparam logic [26:0] RingBits [24] = '{
    27'h0000008, 27'h0000004, 27'h0000002, 27'h0000001, 27'h0004000, 27'h0002000,
    27'h0001000, 27'h0000800, 27'h0000400, 27'h0000200, 27'h0000100, 27'h0400000,
    27'h0200000, 27'h0100000, 27'h0080000, 27'h0040000, 27'h0020000, 27'h0010000,
    27'h4000000, 27'h2000000, 27'h1000000, 27'h0000040, 27'h0000020, 27'h0000010
  };

endpackage

>>> rtl/core/touch_wheel_wrap_guard.sv
// Touch wheel brightness tracker with wrap-around guard and LED ring drawing.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one item per transfer,
// either a local wheel sample or a remote brightness set. Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result per item, in
// order: accept flag, current brightness and the 27-bit ring shift pattern.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes jump_limit;
// it is always ready. The user must write it only while no item is in flight;
// the block does not enforce this.
//
// An item lands in the input register; the tracking logic then updates the
// state and loads the result register. The state update is a single
// compare-and-select step, so back-to-back items see each other's state.
// Throughput is one item per cycle; when the receiver stalls, the result
// register holds, and in_stall_o rises once the input register holds an item.
//
// Reset: brightness 0, ring dark, clockwise tracking enabled, jump_limit 100,
// both pipeline registers empty.
module touch_wheel_wrap_guard #(
  parameter int unsigned RING_LEDS = twwg_pkg::RingLedsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  twwg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output twwg_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  localparam logic [4:0] TopMax = 5'(RING_LEDS - 1);

  function automatic logic [26:0] draw_ring(logic [7:0] v);
    logic [7:0]  vc;
    logic [17:0] prod;
    logic [4:0]  top;
    logic [26:0] pat;
    vc   = (v > twwg_pkg::RingClampValue) ? twwg_pkg::RingFullValue : v;
    prod = 18'(vc) * twwg_pkg::DivElevenMul;
    top  = prod[twwg_pkg::DivElevenShift +: 5];
    if (top > TopMax) top = TopMax;
    pat = '0;
    for (int k = 0; k < RING_LEDS; k++) begin
      if (5'(k) <= top) pat |= twwg_pkg::RingBits[k];
    end
    return pat;
  endfunction

  logic [7:0]          jump_q;
  logic [7:0]          last_q, last_d;
  logic [7:0]          guard_q, guard_d;
  twwg_pkg::dir_e      dir_q, dir_d;
  logic                track_q, track_d;
  logic [26:0]         ring_q, ring_d;
  logic                acc_d;

  logic                s1_valid_q;
  twwg_pkg::in_item_t  s1_q;
  logic                out_valid_q;
  twwg_pkg::out_item_t out_q;

  logic                out_ready;
  logic                fire;
  logic                in_xfer;
  logic [7:0]          v;
  logic [7:0]          diff_last;
  logic [7:0]          diff_guard;

  assign cfg_ready_o = 1'b1;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign v          = s1_q.wheel_value;
  assign diff_last  = (v > last_q) ? v - last_q : last_q - v;
  assign diff_guard = (v > guard_q) ? v - guard_q : guard_q - v;

  always_comb begin
    last_d  = last_q;
    guard_d = guard_q;
    dir_d   = dir_q;
    track_d = track_q;
    ring_d  = ring_q;
    acc_d   = 1'b0;
    if (s1_q.op == twwg_pkg::OpRemote) begin
      last_d = v;
      ring_d = draw_ring(v);
      acc_d  = 1'b1;
    end else if (diff_last < jump_q && track_q) begin
      dir_d   = (v > last_q) ? twwg_pkg::DirCwTrack : twwg_pkg::DirCcwTrack;
      last_d  = v;
      guard_d = v;
      ring_d  = draw_ring(v);
      acc_d   = 1'b1;
    end else begin
      // large jump or tracking off: treat as seam crossing, wait for motion back
      unique case (dir_q)
        twwg_pkg::DirCwTrack: begin
          track_d = 1'b0;
          dir_d   = twwg_pkg::DirCwBlock;
          guard_d = v;
        end
        twwg_pkg::DirCwBlock: begin
          if (v < guard_q && diff_guard < jump_q) track_d = 1'b1;
          else guard_d = v;
        end
        twwg_pkg::DirCcwTrack: begin
          track_d = 1'b0;
          dir_d   = twwg_pkg::DirCcwBlock;
          guard_d = v;
        end
        twwg_pkg::DirCcwBlock: begin
          if (v > guard_q && diff_guard < jump_q) track_d = 1'b1;
          else guard_d = v;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q      <= twwg_pkg::JumpLimitReset;
      last_q      <= '0;
      guard_q     <= '0;
      dir_q       <= twwg_pkg::DirCwTrack;
      track_q     <= 1'b1;
      ring_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) jump_q <= cfg_data_i;
      if (fire) begin
        last_q  <= last_d;
        guard_q <= guard_d;
        dir_q   <= dir_d;
        track_q <= track_d;
        ring_q  <= ring_d;
      end
      if (in_xfer) s1_valid_q <= 1'b1;
      else if (fire) s1_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_q <= in_data_i;
    if (fire) begin
      out_q.accepted   <= acc_d;
      out_q.brightness <= last_d;
      out_q.ring_mask  <= ring_d;
    end
  end

`include "touch_wheel_wrap_guard_assert.svh"

  `TWWG_ASSERT(a_blocked_when_untracked, !track_q |-> (dir_q == twwg_pkg::DirCwBlock || dir_q == twwg_pkg::DirCcwBlock), "tracking off outside a blocked state")
  `TWWG_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled with empty input register")
  `TWWG_ASSERT(a_remote_accepted, (fire && s1_q.op == twwg_pkg::OpRemote) |=> (out_valid_q && out_q.accepted && out_q.brightness == last_q), "remote set not reported as accepted")
  `TWWG_ASSERT(a_out_held, (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)), "stalled result changed")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the touch wheel wrap guard: wheel walks, wraps, remote sets.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned MaxWait     = 19;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned SegWidth    = 11;
  localparam int unsigned MaxStride   = 40;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  twwg_pkg::in_item_t  in_data_i   = '0;
  logic                out_stall_i = 1'b1;
  logic                cfg_valid_i = 1'b0;
  logic [7:0]          cfg_data_i  = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  twwg_pkg::out_item_t out_data_o;
  logic                cfg_ready_o;

  // tracker state mirrored in the testbench
  logic [7:0]     jump_lim  = twwg_pkg::JumpLimitReset;
  logic [7:0]     bright    = '0;
  logic [7:0]     guard_val = '0;
  twwg_pkg::dir_e dir       = twwg_pkg::DirCwTrack;
  logic           tracking  = 1'b1;
  logic [26:0]    ring      = '0;

  twwg_pkg::out_item_t expected_q[$];
  bit                  quiet       = 1'b0;
  int                  bad_results = 0;
  int                  idle_cycles = 0;

  touch_wheel_wrap_guard dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Bar graph: positions 0..v/11 lit, values above the clamp drawn as full.
  function automatic logic [26:0] ring_for(logic [7:0] v);
    int seg;
    logic [26:0] pat;
    pat = '0;
    seg = (v > twwg_pkg::RingClampValue) ? int'(twwg_pkg::RingFullValue) / SegWidth
                                         : int'(v) / SegWidth;
    if (seg > twwg_pkg::RingLedsDefault - 1) seg = twwg_pkg::RingLedsDefault - 1;
    for (int k = 0; k <= seg; k++) pat |= twwg_pkg::RingBits[k];
    return pat;
  endfunction

  function automatic twwg_pkg::out_item_t track_sample(twwg_pkg::in_item_t it);
    logic [7:0] v;
    int step, gstep;
    twwg_pkg::out_item_t res;
    v = it.wheel_value;
    res = '0;
    step  = (v > bright) ? int'(v - bright) : int'(bright - v);
    gstep = (v > guard_val) ? int'(v - guard_val) : int'(guard_val - v);
    if (it.op == twwg_pkg::OpRemote) begin
      bright = v;
      ring = ring_for(v);
      res.accepted = 1'b1;
    end else if (step < jump_lim && tracking) begin
      dir = (v > bright) ? twwg_pkg::DirCwTrack : twwg_pkg::DirCcwTrack;
      bright = v;
      guard_val = v;
      ring = ring_for(v);
      res.accepted = 1'b1;
    end else begin
      // large jump or tracking off: block until the wheel comes back the other way
      case (dir)
        twwg_pkg::DirCwTrack: begin
          tracking = 1'b0;
          dir = twwg_pkg::DirCwBlock;
          guard_val = v;
        end
        twwg_pkg::DirCwBlock: begin
          if (v < guard_val && gstep < jump_lim) tracking = 1'b1;
          else guard_val = v;
        end
        twwg_pkg::DirCcwTrack: begin
          tracking = 1'b0;
          dir = twwg_pkg::DirCcwBlock;
          guard_val = v;
        end
        twwg_pkg::DirCcwBlock: begin
          if (v > guard_val && gstep < jump_lim) tracking = 1'b1;
          else guard_val = v;
        end
        default: ;
      endcase
    end
    res.brightness = bright;
    res.ring_mask = ring;
    return res;
  endfunction

  task automatic send_item(input twwg_pkg::op_e op, input logic [7:0] v);
    int gap;
    twwg_pkg::in_item_t it;
    it.op = op;
    it.wheel_value = v;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_q.push_back(track_sample(it));
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] lim);
    go_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    jump_lim = lim;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wheel turning in runs with random reversals; position wraps over the seam.
  task automatic walk_phase(input int n);
    logic [7:0] pos;
    int dirn, maxstep, mag, sel;
    pos = bright;
    dirn = ($urandom_range(0, 1) == 0) ? 1 : -1;
    maxstep = (jump_lim > 1) ? ((jump_lim - 1 < MaxStride) ? jump_lim - 1 : MaxStride) : 1;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_item(twwg_pkg::OpRemote, 8'($urandom_range(0, 255)));
      end else if (sel < 16) begin
        send_item(twwg_pkg::OpLocal, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) == 0) dirn = -dirn;
        mag = $urandom_range(0, maxstep);
        pos = pos + 8'(dirn * mag);
        send_item(twwg_pkg::OpLocal, pos);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_directed();
    send_item(twwg_pkg::OpLocal, 8'd0);     // equal value counts as counter-clockwise
    send_item(twwg_pkg::OpLocal, 8'd50);
    send_item(twwg_pkg::OpLocal, 8'd149);   // one below the limit
    send_item(twwg_pkg::OpLocal, 8'd249);   // exactly the limit: clockwise wrap, blocked
    send_item(twwg_pkg::OpLocal, 8'd255);   // same way: guard follows
    send_item(twwg_pkg::OpLocal, 8'd200);   // back the other way: tracking again
    send_item(twwg_pkg::OpLocal, 8'd160);
    send_item(twwg_pkg::OpLocal, 8'd120);
    send_item(twwg_pkg::OpLocal, 8'd10);    // counter-clockwise wrap, blocked
    send_item(twwg_pkg::OpLocal, 8'd5);
    send_item(twwg_pkg::OpLocal, 8'd60);    // back up within the limit: tracking again
    send_item(twwg_pkg::OpLocal, 8'd100);
    send_item(twwg_pkg::OpRemote, 8'd255);
    send_item(twwg_pkg::OpRemote, 8'd241);
    send_item(twwg_pkg::OpRemote, 8'd240);
    send_item(twwg_pkg::OpRemote, 8'd11);
    send_item(twwg_pkg::OpRemote, 8'd10);
    send_item(twwg_pkg::OpRemote, 8'd0);
    send_item(twwg_pkg::OpLocal, 8'd255);
    send_item(twwg_pkg::OpLocal, 8'd128);
    send_item(twwg_pkg::OpLocal, 8'd127);
  endtask

  task automatic test_limit_extremes();
    write_limit(8'd1);
    walk_phase(150);
    write_limit(8'd255);
    walk_phase(150);
    write_limit(8'd0);            // nothing local gets through
    walk_phase(150);
  endtask

  task automatic test_random_limits();
    repeat (5) begin
      write_limit(8'($urandom_range(1, 255)));
      walk_phase(240);
    end
  endtask

  // receiver: random stall before each result
  initial begin
    int gap;
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    twwg_pkg::out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MaxReports)
          $display("unexpected result: acc=%0d bright=%0d ring=%h",
                   out_data_o.accepted, out_data_o.brightness, out_data_o.ring_mask);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.accepted !== want.accepted || out_data_o.brightness !== want.brightness ||
            out_data_o.ring_mask !== want.ring_mask) begin
          bad_results++;
          if (bad_results <= MaxReports)
            $display("mismatch: want acc=%0d bright=%0d ring=%h, got acc=%0d bright=%0d ring=%h",
                     want.accepted, want.brightness, want.ring_mask, out_data_o.accepted,
                     out_data_o.brightness, out_data_o.ring_mask);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_random_limits();
    go_idle();
    if (bad_results == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/twwg_pkg.sv
rtl/core/touch_wheel_wrap_guard.sv
tb/sv/tb.sv
